>>> design/bvm_pkg.sv
// Shared types and codes for the bounding volume merge block.
package bvm_pkg;

  localparam int COORD_BITS_DEF = 48;

  localparam int ROWS = 4;
  localparam int COLS = 3;

  localparam logic [1:0] KIND_BOX    = 2'd0;
  localparam logic [1:0] KIND_REGION = 2'd1;
  localparam logic [1:0] KIND_SPHERE = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_MERGE = 1'b1;

  typedef enum logic [1:0] {
    SER_MUL,
    SER_SQRT,
    SER_DIV
  } ser_op_t;

  typedef struct packed {
    logic    start;
    ser_op_t op;
  } ser_req_t;

  typedef struct packed {
    logic       start;
    logic [1:0] kind;
  } merge_req_t;

endpackage

>>> design/bvm_serial.sv
// Bit-serial multiply, square root and divide unit.
module bvm_serial #(
  parameter int COORD_BITS = bvm_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bvm_pkg::ser_req_t         req,
  input  logic [COORD_BITS-1:0]     opa,
  input  logic [COORD_BITS-1:0]     opb,
  input  logic [2*COORD_BITS-1:0]   opn,
  output logic                      done,
  output logic [2*COORD_BITS-1:0]   prod,
  output logic [COORD_BITS-1:0]     root,
  output logic [2*COORD_BITS-1:0]   quot
);

  localparam int CB = COORD_BITS;
  localparam int CW = $clog2(2 * CB + 1);
  localparam logic [CW-1:0] STEPS_SHORT = CW'(CB - 1);
  localparam logic [CW-1:0] STEPS_LONG  = CW'(2 * CB - 1);

  logic                busy_r;
  logic                done_r;
  bvm_pkg::ser_op_t    op_r;
  logic [CW-1:0]       cnt_r;
  logic [CB+1:0]       hi_r;
  logic [2*CB-1:0]     lo_r;
  logic [CB-1:0]       aux_r;

  logic [CB+1:0]       hi_nxt;
  logic [2*CB-1:0]     lo_nxt;
  logic [CB-1:0]       aux_nxt;
  logic [CB:0]         mul_sum;
  logic [CB+3:0]       sq_rem;
  logic [CB+3:0]       sq_trial;
  logic [CB+3:0]       sq_diff;
  logic [CB:0]         dv_rem;
  logic [CB:0]         dv_div;
  logic [CW-1:0]       last_step;

  // One digit of the selected recurrence per cycle.
  always_comb begin
    mul_sum  = {1'b0, hi_r[CB-1:0]} + (lo_r[0] ? {1'b0, aux_r} : '0);
    sq_rem   = {hi_r, lo_r[2*CB-1:2*CB-2]};
    sq_trial = {2'b00, aux_r, 2'b01};
    sq_diff  = sq_rem - sq_trial;
    dv_rem   = {hi_r[CB-1:0], lo_r[2*CB-1]};
    dv_div   = {1'b0, aux_r};
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    aux_nxt  = aux_r;
    case (op_r)
      bvm_pkg::SER_MUL: begin
        hi_nxt = {2'b00, mul_sum[CB:1]};
        lo_nxt = {lo_r[2*CB-1:CB], mul_sum[0], lo_r[CB-1:1]};
      end
      bvm_pkg::SER_SQRT: begin
        lo_nxt = {lo_r[2*CB-3:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          hi_nxt  = sq_diff[CB+1:0];
          aux_nxt = {aux_r[CB-2:0], 1'b1};
        end else begin
          hi_nxt  = sq_rem[CB+1:0];
          aux_nxt = {aux_r[CB-2:0], 1'b0};
        end
      end
      bvm_pkg::SER_DIV: begin
        if (dv_rem >= dv_div) begin
          hi_nxt = {1'b0, dv_rem - dv_div};
          lo_nxt = {lo_r[2*CB-2:0], 1'b1};
        end else begin
          hi_nxt = {1'b0, dv_rem};
          lo_nxt = {lo_r[2*CB-2:0], 1'b0};
        end
      end
      default: begin
        hi_nxt = hi_r;
      end
    endcase
    last_step = (op_r == bvm_pkg::SER_DIV) ? STEPS_LONG : STEPS_SHORT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= bvm_pkg::SER_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        hi_r   <= '0;
        case (req.op)
          bvm_pkg::SER_MUL: begin
            lo_r  <= {{CB{1'b0}}, opb};
            aux_r <= opa;
          end
          bvm_pkg::SER_SQRT: begin
            lo_r  <= opn;
            aux_r <= '0;
          end
          default: begin
            lo_r  <= opn;
            aux_r <= opa;
          end
        endcase
      end else if (busy_r) begin
        hi_r  <= hi_nxt;
        lo_r  <= lo_nxt;
        aux_r <= aux_nxt;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r[CB-1:0], lo_r[CB-1:0]};
  assign root = aux_r;
  assign quot = lo_r;

endmodule

>>> design/bvm_merge.sv
// Merge sequencer: box, region and sphere union of two stored volumes.
module bvm_merge #(
  parameter int COORD_BITS = bvm_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bvm_pkg::merge_req_t          req,
  input  logic signed [COORD_BITS-1:0] p   [4][3],
  input  logic signed [COORD_BITS-1:0] q   [4][3],
  output logic signed [COORD_BITS-1:0] res [4][3],
  output logic                         done
);

  localparam int CB = COORD_BITS;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_BOX_E1, S_BOX_E2, S_BOX_LO, S_BOX_HI, S_BOX_WR, S_REG0, S_REG1,
    S_SPH_D, S_SPH_SQ, S_SPH_SQW, S_SPH_RT, S_SPH_RTW, S_SPH_CMP, S_SPH_NR,
    S_SPH_NUM, S_SPH_MUL, S_SPH_MULW, S_SPH_DIV, S_SPH_DIVW, S_DONE
  } state_t;

  function automatic logic signed [CB-1:0] clampw(input logic signed [CB+1:0] x);
    logic [2:0] tb;
    tb = x[CB+1:CB-1];
    if (tb == 3'b000 || tb == 3'b111) return x[CB-1:0];
    else if (x[CB+1]) return CMIN;
    else return CMAX;
  endfunction

  function automatic logic signed [CB-1:0] satadd(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b);
    return clampw({{2{a[CB-1]}}, a} + {{2{b[CB-1]}}, b});
  endfunction

  function automatic logic signed [CB-1:0] satsub(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b);
    return clampw({{2{a[CB-1]}}, a} - {{2{b[CB-1]}}, b});
  endfunction

  function automatic logic signed [CB-1:0] sabs(input logic signed [CB-1:0] a);
    if (a == CMIN) return CMAX;
    else if (a[CB-1]) return -a;
    else return a;
  endfunction

  function automatic logic [CB-1:0] mag(input logic signed [CB-1:0] a);
    return a[CB-1] ? (CB'(0) - a) : a;
  endfunction

  function automatic logic signed [CB-1:0] smin(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CB-1:0] smax(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  state_t                state_r;
  logic                  done_r;
  logic [1:0]            ax_r;
  logic signed [CB-1:0]  ep_r, eq_r, lo_r, hi_r;
  logic signed [CB-1:0]  d_r [3];
  logic [2*CB-1:0]       sum_r;
  logic signed [CB-1:0]  dist_r, nr_r, num_r;
  logic signed [CB-1:0]  res_r [4][3];

  bvm_pkg::ser_req_t     ser_req;
  logic [CB-1:0]         ser_a, ser_b;
  logic [2*CB-1:0]       ser_n;
  logic                  ser_done;
  logic [2*CB-1:0]       ser_prod, ser_quot;
  logic [CB-1:0]         ser_root;

  logic signed [CB:0]    mid_w, dif_w;
  logic signed [CB-1:0]  num_w;
  logic [CB-1:0]         quo_w;
  logic signed [CB:0]    off_w;
  logic signed [CB-1:0]  moved_w;

  always_comb begin
    mid_w   = {lo_r[CB-1], lo_r} + {hi_r[CB-1], hi_r};
    dif_w   = {hi_r[CB-1], hi_r} - {lo_r[CB-1], lo_r};
    num_w   = satsub(nr_r, p[1][0]);
    quo_w   = ser_quot[CB-1:0];
    off_w   = d_r[ax_r][CB-1] ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
    moved_w = clampw({{2{p[0][ax_r][CB-1]}}, p[0][ax_r]} + {off_w[CB], off_w});
  end

  always_comb begin
    ser_req.start = 1'b0;
    ser_req.op    = bvm_pkg::SER_MUL;
    ser_a         = '0;
    ser_b         = '0;
    ser_n         = '0;
    case (state_r)
      S_SPH_SQ: begin
        ser_req.start = 1'b1;
        ser_a         = mag(d_r[ax_r]);
        ser_b         = mag(d_r[ax_r]);
      end
      S_SPH_RT: begin
        ser_req.start = 1'b1;
        ser_req.op    = bvm_pkg::SER_SQRT;
        ser_n         = sum_r;
      end
      S_SPH_MUL: begin
        ser_req.start = (dist_r != '0);
        ser_a         = mag(d_r[ax_r]);
        ser_b         = num_r;
      end
      S_SPH_DIV: begin
        ser_req.start = 1'b1;
        ser_req.op    = bvm_pkg::SER_DIV;
        ser_a         = dist_r;
        ser_n         = sum_r;
      end
      default: begin
        ser_req.start = 1'b0;
      end
    endcase
  end

  bvm_serial #(.COORD_BITS(COORD_BITS)) u_serial (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ser_req),
    .opa  (ser_a),
    .opb  (ser_b),
    .opn  (ser_n),
    .done (ser_done),
    .prod (ser_prod),
    .root (ser_root),
    .quot (ser_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            ax_r <= 2'd0;
            for (int r = 0; r < 4; r++)
              for (int c = 0; c < 3; c++) res_r[r][c] <= '0;
            if (req.kind == bvm_pkg::KIND_BOX) state_r <= S_BOX_E1;
            else if (req.kind == bvm_pkg::KIND_REGION) state_r <= S_REG0;
            else state_r <= S_SPH_D;
          end
        end
        S_BOX_E1: begin
          ep_r    <= satadd(sabs(p[1][ax_r]), sabs(p[2][ax_r]));
          eq_r    <= satadd(sabs(q[1][ax_r]), sabs(q[2][ax_r]));
          state_r <= S_BOX_E2;
        end
        S_BOX_E2: begin
          ep_r    <= satadd(ep_r, sabs(p[3][ax_r]));
          eq_r    <= satadd(eq_r, sabs(q[3][ax_r]));
          state_r <= S_BOX_LO;
        end
        S_BOX_LO: begin
          lo_r    <= smin(satsub(p[0][ax_r], ep_r), satsub(q[0][ax_r], eq_r));
          state_r <= S_BOX_HI;
        end
        S_BOX_HI: begin
          hi_r    <= smax(satadd(p[0][ax_r], ep_r), satadd(q[0][ax_r], eq_r));
          state_r <= S_BOX_WR;
        end
        S_BOX_WR: begin
          // Center is the floored midpoint, half extent goes on the diagonal.
          res_r[0][ax_r]         <= mid_w[CB:1];
          res_r[ax_r + 2'd1][ax_r] <= dif_w[CB:1];
          if (ax_r == 2'd2) begin
            state_r <= S_DONE;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_BOX_E1;
          end
        end
        S_REG0: begin
          res_r[0][0] <= smin(p[0][0], q[0][0]);
          res_r[0][1] <= smin(p[0][1], q[0][1]);
          res_r[0][2] <= smax(p[0][2], q[0][2]);
          state_r     <= S_REG1;
        end
        S_REG1: begin
          res_r[1][0] <= smax(p[1][0], q[1][0]);
          res_r[1][1] <= smin(p[1][1], q[1][1]);
          res_r[1][2] <= smax(p[1][2], q[1][2]);
          state_r     <= S_DONE;
        end
        S_SPH_D: begin
          d_r[ax_r] <= satsub(q[0][ax_r], p[0][ax_r]);
          if (ax_r == 2'd2) begin
            ax_r    <= 2'd0;
            sum_r   <= '0;
            state_r <= S_SPH_SQ;
          end else begin
            ax_r <= ax_r + 2'd1;
          end
        end
        S_SPH_SQ: begin
          state_r <= S_SPH_SQW;
        end
        S_SPH_SQW: begin
          if (ser_done) begin
            sum_r <= sum_r + ser_prod;
            if (ax_r == 2'd2) begin
              ax_r    <= 2'd0;
              state_r <= S_SPH_RT;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_SPH_SQ;
            end
          end
        end
        S_SPH_RT: begin
          state_r <= S_SPH_RTW;
        end
        S_SPH_RTW: begin
          if (ser_done) begin
            dist_r  <= ser_root[CB-1] ? CMAX : $signed(ser_root);
            state_r <= S_SPH_CMP;
          end
        end
        S_SPH_CMP: begin
          // One sphere may already hold the other.
          if (satadd(dist_r, q[1][0]) <= p[1][0]) begin
            res_r   <= p;
            state_r <= S_DONE;
          end else if (satadd(dist_r, p[1][0]) <= q[1][0]) begin
            res_r   <= q;
            state_r <= S_DONE;
          end else begin
            nr_r    <= satadd(dist_r, p[1][0]);
            state_r <= S_SPH_NR;
          end
        end
        S_SPH_NR: begin
          nr_r    <= satadd(nr_r, q[1][0]) >>> 1;
          state_r <= S_SPH_NUM;
        end
        S_SPH_NUM: begin
          if (num_w < 0) num_r <= '0;
          else if (num_w > dist_r) num_r <= dist_r;
          else num_r <= num_w;
          res_r[1][0] <= nr_r;
          ax_r        <= 2'd0;
          state_r     <= S_SPH_MUL;
        end
        S_SPH_MUL: begin
          if (dist_r == '0) begin
            res_r[0][ax_r] <= p[0][ax_r];
            if (ax_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end else begin
            state_r <= S_SPH_MULW;
          end
        end
        S_SPH_MULW: begin
          if (ser_done) begin
            sum_r   <= ser_prod;
            state_r <= S_SPH_DIV;
          end
        end
        S_SPH_DIV: begin
          state_r <= S_SPH_DIVW;
        end
        S_SPH_DIVW: begin
          if (ser_done) begin
            res_r[0][ax_r] <= moved_w;
            if (ax_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_SPH_MUL;
            end
          end
        end
        S_DONE: begin
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

>>> design/bounding_volume_merge.sv
// Top level of the bounding volume merge block: row staging, accumulator, result rows.
// A row that is not last is taken while idle or while the answer drains; a last row only
// while idle. A load writes the accumulator, then the emit state registers the first result
// word; a mismatch goes straight to emit. A sphere merge waits on the bit-serial multiply,
// root and divide unit. Rows of the answer leave one per cycle while out_stall is low.
// Synchronous active-low reset empties the accumulator and the row count.
module bounding_volume_merge #(
  parameter int COORD_BITS = bvm_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [1:0]                   in_kind,
  input  logic signed [COORD_BITS-1:0] in_comp_a,
  input  logic signed [COORD_BITS-1:0] in_comp_b,
  input  logic signed [COORD_BITS-1:0] in_comp_c,
  input  logic                         in_last_row,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [1:0]                   out_kind,
  output logic signed [COORD_BITS-1:0] out_a,
  output logic signed [COORD_BITS-1:0] out_b,
  output logic signed [COORD_BITS-1:0] out_c,
  output logic                         out_final_row
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MSTART, S_MWAIT, S_EMIT, S_OUT} state_t;

  function automatic logic [2:0] rows_for(input logic [1:0] kind);
    if (kind == bvm_pkg::KIND_BOX) return 3'd4;
    else if (kind == bvm_pkg::KIND_REGION || kind == bvm_pkg::KIND_SPHERE) return 3'd2;
    else return 3'd0;
  endfunction

  state_t                       state_r;
  logic [1:0]                   rc_r;
  logic                         acc_valid_r;
  logic [1:0]                   acc_kind_r;
  logic [1:0]                   kind_r;
  logic                         status_r;
  logic [1:0]                   k_r;
  logic                         out_valid_r;
  logic                         out_final_r;
  logic signed [COORD_BITS-1:0] out_a_r, out_b_r, out_c_r;
  logic signed [COORD_BITS-1:0] acc_r [4][3];
  logic signed [COORD_BITS-1:0] st_r  [4][3];

  logic                         in_acc;
  logic                         radius;
  logic [1:0]                   n_last;
  logic [1:0]                   k_nxt;
  bvm_pkg::merge_req_t          mrg_req;
  logic signed [COORD_BITS-1:0] mrg_res [4][3];
  logic                         mrg_done;

  // Rows that only stage data may also come in while the answer drains.
  assign in_stall = !(state_r == S_IDLE || (state_r == S_OUT && !in_last_row));
  assign in_acc   = in_valid && !in_stall;
  assign radius   = (in_kind == bvm_pkg::KIND_SPHERE) && (rc_r == 2'd1);
  assign n_last   = (acc_kind_r == bvm_pkg::KIND_BOX) ? 2'd3 : 2'd1;
  assign k_nxt    = k_r + 2'd1;

  assign mrg_req.start = (state_r == S_MSTART);
  assign mrg_req.kind  = acc_kind_r;

  bvm_merge #(.COORD_BITS(COORD_BITS)) u_merge (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mrg_req),
    .p    (acc_r),
    .q    (st_r),
    .res  (mrg_res),
    .done (mrg_done)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (rc_r == 2'd0) begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 3; c++) st_r[r][c] <= '0;
      end
      if ({1'b0, rc_r} < rows_for(in_kind)) begin
        st_r[rc_r][0] <= in_comp_a;
        st_r[rc_r][1] <= radius ? '0 : in_comp_b;
        st_r[rc_r][2] <= radius ? '0 : in_comp_c;
      end
    end
    if (state_r == S_LOAD) begin
      acc_r <= st_r;
    end else if (state_r == S_MWAIT && mrg_done) begin
      acc_r <= mrg_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rc_r        <= 2'd0;
      acc_valid_r <= 1'b0;
      acc_kind_r  <= bvm_pkg::KIND_BOX;
      kind_r      <= bvm_pkg::KIND_BOX;
      status_r    <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
      out_final_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_last_row) rc_r <= 2'd0;
        else if (rc_r != 2'd3) rc_r <= rc_r + 2'd1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_last_row) begin
            if (in_kind > bvm_pkg::KIND_SPHERE) begin
              status_r <= 1'b1;
              state_r  <= S_EMIT;
            end else if (in_action == bvm_pkg::ACT_LOAD || !acc_valid_r) begin
              status_r <= 1'b0;
              kind_r   <= in_kind;
              state_r  <= S_LOAD;
            end else if (in_kind != acc_kind_r) begin
              status_r <= 1'b1;
              state_r  <= S_EMIT;
            end else begin
              status_r <= 1'b0;
              state_r  <= S_MSTART;
            end
          end
        end
        S_LOAD: begin
          acc_kind_r  <= kind_r;
          acc_valid_r <= 1'b1;
          state_r     <= S_EMIT;
        end
        S_MSTART: begin
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mrg_done) state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          k_r         <= 2'd0;
          out_a_r     <= acc_r[0][0];
          out_b_r     <= acc_r[0][1];
          out_c_r     <= acc_r[0][2];
          out_final_r <= 1'b0;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (k_r == n_last) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              k_r         <= k_nxt;
              out_a_r     <= acc_r[k_nxt][0];
              out_b_r     <= acc_r[k_nxt][1];
              out_c_r     <= acc_r[k_nxt][2];
              out_final_r <= (k_nxt == n_last);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_kind      = acc_kind_r;
  assign out_a         = out_a_r;
  assign out_b         = out_b_r;
  assign out_c         = out_c_r;
  assign out_final_row = out_final_r;

`ifndef SYNTHESIS
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT)
    else $error("result word valid outside the output state");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> k_r <= n_last)
    else $error("result row index beyond the accumulator's row count");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_final_row) |=> !out_valid)
    else $error("result word after the final row");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_done |-> state_r == S_MWAIT)
    else $error("merge finished while not awaited");
`endif

endmodule

>>> tb/bounding_volume_merge_tb.sv
// Self-checking testbench for the bounding volume merge block.
module bounding_volume_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 48;
  localparam longint CMAX = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int MAX_CYCLES = 2000000;
  localparam int ITEM_TARGET = 400;

  typedef struct {
    logic          action;
    logic [1:0]    kind;
    logic [CB-1:0] a, b, c;
    logic          last;
    bit            drain;
  } row_word_t;

  typedef struct {
    logic                 status;
    logic [1:0]           kind;
    logic signed [CB-1:0] a, b, c;
    logic                 fin;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = 1'b0;
  logic [1:0] in_kind = '0;
  logic signed [CB-1:0] in_comp_a = '0, in_comp_b = '0, in_comp_c = '0;
  logic in_last_row = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [1:0] out_kind;
  logic signed [CB-1:0] out_a, out_b, out_c;
  logic out_final_row;

  bounding_volume_merge #(.COORD_BITS(CB)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  row_word_t    pending_rows[$];
  result_word_t expected_rows[$];
  int  errors = 0;
  int  cycles = 0;
  int  item_count = 0;
  bit  sent_word = 0;

  // Predictor state.
  bit         acc_ok;
  logic [1:0] acc_k;
  longint     acc[12];
  longint     stg[12];
  int         row_cnt;

  function automatic longint clampc(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic longint sadd(longint x, longint y);
    return clampc(x + y);
  endfunction

  function automatic longint ssub(longint x, longint y);
    return clampc(x - y);
  endfunction

  function automatic longint sabs(longint x);
    return x < 0 ? clampc(-x) : x;
  endfunction

  function automatic int rows_of(logic [1:0] k);
    return k == bvm_pkg::KIND_BOX ? 4 : (k <= bvm_pkg::KIND_SPHERE ? 2 : 0);
  endfunction

  function automatic void merge_boxes(output longint r[12], input longint p[12],
                                      input longint q[12]);
    longint ep, eq, lo, hi;
    foreach (r[i]) r[i] = 0;
    for (int ax = 0; ax < 3; ax++) begin
      ep = sadd(sadd(sabs(p[3+ax]), sabs(p[6+ax])), sabs(p[9+ax]));
      eq = sadd(sadd(sabs(q[3+ax]), sabs(q[6+ax])), sabs(q[9+ax]));
      lo = ssub(p[ax], ep) < ssub(q[ax], eq) ? ssub(p[ax], ep) : ssub(q[ax], eq);
      hi = sadd(p[ax], ep) > sadd(q[ax], eq) ? sadd(p[ax], ep) : sadd(q[ax], eq);
      r[ax] = (lo >>> 1) + (hi >>> 1) + ((lo[0] && hi[0]) ? 1 : 0);
      r[3 + ax*4] = (hi - lo) >>> 1;
    end
  endfunction

  function automatic void merge_spheres(output longint r[12], input longint p[12],
                                        input longint q[12]);
    longint d[3], span, nr, num, off;
    logic [127:0] mag[3], sq, rt, t, m;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = ssub(q[i], p[i]);
      mag[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
      sq += mag[i] * mag[i];
    end
    rt = '0;
    for (int bt = 63; bt >= 0; bt--) begin
      t = rt | (128'd1 << bt);
      if (t * t <= sq) rt = t;
    end
    span = rt > 128'(CMAX) ? CMAX : longint'(rt);
    if (sadd(span, q[3]) <= p[3]) begin
      r = p;
      return;
    end
    if (sadd(span, p[3]) <= q[3]) begin
      r = q;
      return;
    end
    foreach (r[i]) r[i] = 0;
    nr = sadd(sadd(span, p[3]), q[3]) >>> 1;
    num = ssub(nr, p[3]);
    if (num < 0) num = 0;
    if (num > span) num = span;
    for (int i = 0; i < 3; i++) begin
      off = 0;
      if (span > 0) begin
        m = (mag[i] * 128'(num)) / 128'(span);
        off = d[i] < 0 ? -longint'(m[62:0]) : longint'(m[62:0]);
      end
      r[i] = sadd(p[i], off);
    end
    r[3] = clampc(nr);
  endfunction

  // Folds one accepted row word into the predicted accumulator.
  function automatic void predict_row(row_word_t w);
    logic status;
    longint res[12];
    logic signed [CB-1:0] fa, fb, fc;
    result_word_t e;
    int n;
    status = 1'b0;
    fa = w.a;
    fb = w.b;
    fc = w.c;
    if (row_cnt == 0) foreach (stg[i]) stg[i] = 0;
    if (row_cnt < rows_of(w.kind)) begin
      stg[row_cnt*3] = fa;
      stg[row_cnt*3+1] = (w.kind == bvm_pkg::KIND_SPHERE && row_cnt == 1) ? 0 : longint'(fb);
      stg[row_cnt*3+2] = (w.kind == bvm_pkg::KIND_SPHERE && row_cnt == 1) ? 0 : longint'(fc);
    end
    if (!w.last) begin
      if (row_cnt < 3) row_cnt++;
      return;
    end
    row_cnt = 0;
    if (w.kind > bvm_pkg::KIND_SPHERE) status = 1'b1;
    else if (w.action == bvm_pkg::ACT_LOAD || !acc_ok) begin
      acc = stg;
      acc_k = w.kind;
      acc_ok = 1;
    end else if (w.kind != acc_k) status = 1'b1;
    else begin
      if (w.kind == bvm_pkg::KIND_BOX) merge_boxes(res, acc, stg);
      else if (w.kind == bvm_pkg::KIND_REGION) begin
        foreach (res[i]) res[i] = 0;
        res[0] = acc[0] < stg[0] ? acc[0] : stg[0];
        res[1] = acc[1] < stg[1] ? acc[1] : stg[1];
        res[2] = acc[2] > stg[2] ? acc[2] : stg[2];
        res[3] = acc[3] > stg[3] ? acc[3] : stg[3];
        res[4] = acc[4] < stg[4] ? acc[4] : stg[4];
        res[5] = acc[5] > stg[5] ? acc[5] : stg[5];
      end else merge_spheres(res, acc, stg);
      acc = res;
    end
    n = rows_of(acc_k);
    for (int k = 0; k < n; k++) begin
      e.status = status;
      e.kind = acc_k;
      e.a = acc[k*3][CB-1:0];
      e.b = acc[k*3+1][CB-1:0];
      e.c = acc[k*3+2][CB-1:0];
      e.fin = (k == n - 1);
      expected_rows.push_back(e);
    end
  endfunction

  // Coordinate flavors, in order: close range, any value, edge values; any other flavor gives a small positive value.
  function automatic longint pick_coord(int flavor);
    logic [CB-1:0] raw;
    case (flavor)
      0: return longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      1: begin
        raw = CB'({$urandom, $urandom});
        return longint'($signed(raw));
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return CMAX;
          1: return CMIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return longint'($urandom_range(0, 1 << 19));
    endcase
  endfunction

  task automatic add_row(logic act, logic [1:0] k, longint a, longint b, longint c, logic last,
                         bit drain = 0);
    row_word_t w;
    w.action = act;
    w.kind = k;
    w.a = a[CB-1:0];
    w.b = b[CB-1:0];
    w.c = c[CB-1:0];
    w.last = last;
    w.drain = drain;
    pending_rows.push_back(w);
    item_count++;
  endtask

  task automatic add_volume(logic act, logic [1:0] k, int flavor, int nrows = -1);
    int n;
    n = nrows < 0 ? (k > bvm_pkg::KIND_SPHERE ? 1 : rows_of(k)) : nrows;
    for (int i = 0; i < n; i++) begin
      if (k == bvm_pkg::KIND_SPHERE && i == 1)
        add_row(act, k, flavor == 0 ? pick_coord(3) : pick_coord(flavor), pick_coord(1),
                pick_coord(1), i == n - 1);
      else
        add_row(act, k, pick_coord(flavor), pick_coord(flavor), pick_coord(flavor), i == n - 1);
    end
  endtask

  initial begin
    logic [1:0] k;
    acc_ok = 0;
    acc_k = bvm_pkg::KIND_BOX;
    row_cnt = 0;
    foreach (acc[i]) acc[i] = 0;
    foreach (stg[i]) stg[i] = 0;

    // Directed part. A merge into the empty accumulator comes first, so nothing unwritten is read.
    add_volume(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_REGION, 2);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_BOX, CMAX, CMIN, CMAX, 1'b0);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_BOX, CMIN, CMAX, -1, 1'b0);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_BOX, 0, 1, CMAX, 1'b0);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_BOX, CMAX, CMIN, CMIN, 1'b1);
    add_volume(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_BOX, 0);
    add_volume(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_REGION, 0);
    add_row(bvm_pkg::ACT_MERGE, 2'd3, 5, 6, 7, 1'b1);
    add_volume(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_SPHERE, 0);
    add_volume(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_SPHERE, 0);
    add_row(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_SPHERE, 0, 0, 0, 1'b0);
    add_row(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_SPHERE, 1, 9, 9, 1'b1);
    add_row(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_SPHERE, CMAX, CMAX, CMAX, 1'b0);
    add_row(bvm_pkg::ACT_MERGE, bvm_pkg::KIND_SPHERE, 5, 0, 0, 1'b1);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_REGION, 11, 22, 33, 1'b0);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_REGION, 44, 55, 66, 1'b0);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_REGION, 77, 88, 99, 1'b1, 1);
    add_volume(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_BOX, 0, 2);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_BOX, 1, 2, 3, 1'b0);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_REGION, 4, 5, 6, 1'b0);
    add_row(bvm_pkg::ACT_LOAD, bvm_pkg::KIND_SPHERE, 7, 8, 9, 1'b1);

    // Random part: mostly whole volumes, some broken ones.
    while (item_count < ITEM_TARGET) begin
      k = 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0: add_volume($urandom_range(0, 1), 2'($urandom_range(0, 3)), $urandom_range(0, 2),
                      $urandom_range(1, 6));
        1: begin
          add_row(bvm_pkg::ACT_MERGE, 2'($urandom_range(0, 3)), pick_coord(1), pick_coord(1),
                  pick_coord(1), 1'b0);
          add_row($urandom_range(0, 1), 2'($urandom_range(0, 3)), pick_coord(0), pick_coord(0),
                  pick_coord(0), 1'b1, $urandom_range(0, 7) == 0);
        end
        2: add_volume($urandom_range(0, 3) == 0 ? bvm_pkg::ACT_LOAD : bvm_pkg::ACT_MERGE, k,
                      $urandom_range(1, 2));
        default: add_volume($urandom_range(0, 3) == 0 ? bvm_pkg::ACT_LOAD : bvm_pkg::ACT_MERGE,
                            k, 0);
      endcase
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_rows.size() == 0 && !in_valid && expected_rows.size() == 0);
    repeat (800) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Input side: the word is predicted when it is taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      row_word_t w;
      w.action = in_action;
      w.kind = in_kind;
      w.a = in_comp_a;
      w.b = in_comp_b;
      w.c = in_comp_c;
      w.last = in_last_row;
      w.drain = 0;
      predict_row(w);
      sent_word = 1;
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    row_word_t w;
    if (rst_n && !(in_valid && !sent_word)) begin
      sent_word = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_rows.size() > 0 &&
                   (!pending_rows[0].drain || expected_rows.size() == 0)) begin
        w = pending_rows.pop_front();
        in_valid <= 1'b1;
        in_action <= w.action;
        in_kind <= w.kind;
        in_comp_a <= w.a;
        in_comp_b <= w.b;
        in_comp_c <= w.c;
        in_last_row <= w.last;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else burst_left--;
      end else in_valid <= 1'b0;
    end
  end

  // Output side: the stall mode is drawn at random: no stall, random stalls or a periodic pattern.
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ((cycles / 4) % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    result_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result word a=%0d b=%0d c=%0d", $realtime, out_a, out_b, out_c);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (out_status !== e.status || out_kind !== e.kind || out_a !== e.a || out_b !== e.b ||
            out_c !== e.c || out_final_row !== e.fin) begin
          $display("%0t: mismatch expected st=%0d kind=%0d a=%0d b=%0d c=%0d fin=%0d", $realtime,
                   e.status, e.kind, e.a, e.b, e.c, e.fin);
          $display("%0t:          actual   st=%0d kind=%0d a=%0d b=%0d c=%0d fin=%0d", $realtime,
                   out_status, out_kind, out_a, out_b, out_c, out_final_row);
          errors++;
        end
      end
    end
  end

endmodule
